// File: rtl/core/tournament_elimination_select_defines.svh
// Assertion macros used by the checker of the tournament selector.
`ifndef TOURNAMENT_ELIMINATION_SELECT_DEFINES_SVH
`define TOURNAMENT_ELIMINATION_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tes_pkg.sv
// Package: widths, codes and controller/datapath link types of the tournament selector.
package tes_pkg;

    localparam int POP_MAX_DEF = 64;
    localparam int DRAW_W      = 20;
    localparam int ID_W        = 16;
    localparam int FIT_W       = 32;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 3;
    localparam int LIVE_W      = 7;
    localparam int TARGET_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TOURN = 2'd1,
        CMD_DRAIN = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_RETRY     = 3'd2,
        ST_AT_TARGET = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OSEL_INFO   = 2'd0,
        OSEL_VICTIM = 2'd1,
        OSEL_DRAIN  = 2'd2
    } out_sel_t;

    typedef struct packed {
        logic     take;
        logic     mod_start;
        logic     mod_step;
        logic     rd_pair;
        logic     mag_load;
        logic     shift_init;
        logic     shift_step;
        logic     load_write;
        logic     cnt_dec;
        logic     cnt_clr;
        logic     drain_init;
        logic     drain_rd;
        logic     drain_adv;
        logic     out_load;
        out_sel_t out_sel;
        status_t  out_status;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t item_cmd;
        logic item_valid;
        logic full;
        logic empty;
        logic at_target;
        logic mod_done;
        logic same_pos;
        logic shift_done;
        logic drain_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/tes_item_if.sv
// Interface: input item channel (command, entry and random draws).
interface tes_item_if;
    import tes_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [ID_W-1:0]          ind_id;
    logic signed [FIT_W-1:0]  fitness;
    logic [DRAW_W-1:0]        rand_a;
    logic [DRAW_W-1:0]        rand_b;

    modport source (output valid, cmd, ind_id, fitness, rand_a, rand_b, input ready);
    modport sink (input valid, cmd, ind_id, fitness, rand_a, rand_b, output ready);
endinterface

// File: rtl/core/tes_result_if.sv
// Interface: result channel (status, removed or drained entry, live count).
interface tes_result_if;
    import tes_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [ID_W-1:0]          survivor_id;
    logic signed [FIT_W-1:0]  survivor_fitness;
    logic [LIVE_W-1:0]        live_count;
    logic                     last;

    modport source (output valid, status, survivor_id, survivor_fitness, live_count, last,
                    input ready);
    modport sink (input valid, status, survivor_id, survivor_fitness, live_count, last,
                  output ready);
endinterface

// File: rtl/core/tournament_elimination_select.sv
// Top level: tournament elimination selector over an ordered population table.
//
//  channel  | role   | handshake        | payload
//  ---------+--------+------------------+----------------------------------------------
//  item     | sink   | valid / ready    | cmd, ind_id, fitness, rand_a, rand_b
//  result   | source | valid / ready    | status, survivor_id, survivor_fitness,
//           |        |                  | live_count, last
//  cfg      | write  | cfg_we           | cfg_wdata -> target_size
//
//  One item at a time. A tournament first forms the bit-serial remainder of the
//  draws by the live count, then shifts each entry above the removed one down one
//  slot, one entry per cycle, through the single write port of the population memory.
//  Reset clears the live count and target size; the memory needs no clearing.
//  A stalled result holds in the output register; the next item is accepted meanwhile.
module tournament_elimination_select #(
    parameter int POP_MAX = tes_pkg::POP_MAX_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tes_item_if.sink                     item,
    tes_result_if.source                 result,
    input  logic                         cfg_we,
    input  logic [tes_pkg::TARGET_W-1:0] cfg_wdata
);
    import tes_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t stat;

    tes_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    tes_datapath #(
        .POP_MAX (POP_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

// File: rtl/core/tes_datapath.sv
// Datapath: population memory, remainder units, shift engine and output register.
module tes_datapath #(
    parameter int POP_MAX = tes_pkg::POP_MAX_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tes_item_if.sink                     item,
    tes_result_if.source                 result,
    input  logic                         cfg_we,
    input  logic [tes_pkg::TARGET_W-1:0] cfg_wdata,
    input  tes_pkg::ctl_cmd_t            ctl,
    output tes_pkg::dp_status_t          stat
);
    import tes_pkg::*;

    localparam int CNT_W  = $clog2(POP_MAX + 1);
    localparam int ADDR_W = $clog2(POP_MAX);
    localparam int REM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(DRAW_W + 1);
    localparam int ENT_W  = ID_W + FIT_W;

    logic [TARGET_W-1:0] target_reg;
    logic [CNT_W-1:0]    count_reg;
    cmd_t                cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [FIT_W-1:0]    fit_reg;
    logic [DRAW_W-1:0]   draw_a_reg;
    logic [DRAW_W-1:0]   draw_b_reg;
    logic [REM_W-1:0]    rem_a_reg;
    logic [REM_W-1:0]    rem_b_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [ENT_W-1:0]    mem [POP_MAX];
    logic [ENT_W-1:0]    rd_a_reg;
    logic [ENT_W-1:0]    rd_b_reg;
    logic [FIT_W-1:0]    mag_a_reg;
    logic [FIT_W-1:0]    mag_b_reg;
    logic [ENT_W-1:0]    vic_reg;
    logic [CNT_W-1:0]    rptr_reg;
    logic [ADDR_W-1:0]   wptr_reg;
    logic                pend_reg;
    logic [CNT_W-1:0]    dptr_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [FIT_W-1:0]    out_fit_reg;
    logic [LIVE_W-1:0]   out_live_reg;
    logic                out_last_reg;

    logic [REM_W-1:0]    divisor;
    logic [ADDR_W-1:0]   pos_a;
    logic [ADDR_W-1:0]   pos_b;
    logic [FIT_W-1:0]    mag_a_next;
    logic [FIT_W-1:0]    mag_b_next;
    logic                vic_is_b;
    logic [ADDR_W-1:0]   vic_pos;
    logic                rd_more;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_a_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENT_W-1:0]    mem_wdata;
    logic                accept;
    logic                drain_last;

    // One restoring step: bring in the next draw bit, subtract the divisor if it fits.
    function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r,
                                                  input logic             b,
                                                  input logic [REM_W-1:0] d);
        logic [REM_W-1:0] t;
        t = {r[REM_W-2:0], b};
        return (t >= d) ? (t - d) : t;
    endfunction

    assign accept     = item.valid & ctl.take;
    assign item.ready = ctl.take;

    assign divisor  = REM_W'(count_reg);
    assign pos_a    = rem_a_reg[ADDR_W-1:0];
    assign pos_b    = rem_b_reg[ADDR_W-1:0];

    assign mag_a_next = rd_a_reg[FIT_W-1] ? (~rd_a_reg[FIT_W-1:0] + 1'b1) : rd_a_reg[FIT_W-1:0];
    assign mag_b_next = rd_b_reg[FIT_W-1] ? (~rd_b_reg[FIT_W-1:0] + 1'b1) : rd_b_reg[FIT_W-1:0];
    // On a tie the first draw loses.
    assign vic_is_b = mag_a_reg < mag_b_reg;
    assign vic_pos  = vic_is_b ? pos_b : pos_a;

    assign rd_more    = rptr_reg < count_reg;
    assign drain_last = dptr_reg == (count_reg - 1'b1);

    assign rd_en     = ctl.rd_pair | (ctl.shift_step & rd_more) | ctl.drain_rd;
    assign rd_a_addr = ctl.rd_pair    ? pos_a :
                       ctl.shift_step ? rptr_reg[ADDR_W-1:0] : dptr_reg[ADDR_W-1:0];
    assign mem_we    = ctl.load_write | (ctl.shift_step & pend_reg);
    assign mem_waddr = ctl.load_write ? count_reg[ADDR_W-1:0] : wptr_reg;
    assign mem_wdata = ctl.load_write ? {id_reg, fit_reg} : rd_a_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[pos_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
            rptr_reg   <= '0;
            wptr_reg   <= '0;
            pend_reg   <= 1'b0;
            dptr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end

            if (ctl.load_write)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (ctl.cnt_clr)
            begin
                count_reg <= '0;
            end

            if (ctl.mod_start)
            begin
                step_reg <= '0;
            end
            else if (ctl.mod_step)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (ctl.shift_init)
            begin
                rptr_reg <= CNT_W'(vic_pos) + 1'b1;
                pend_reg <= 1'b0;
            end
            else if (ctl.shift_step)
            begin
                // Read the next entry and write the one fetched last cycle one slot down.
                if (rd_more)
                begin
                    rptr_reg <= rptr_reg + 1'b1;
                    wptr_reg <= rptr_reg[ADDR_W-1:0] - 1'b1;
                end
                pend_reg <= rd_more;
            end

            if (ctl.drain_init)
            begin
                dptr_reg <= '0;
            end
            else if (ctl.drain_adv)
            begin
                dptr_reg <= dptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(item.cmd);
            id_reg     <= item.ind_id;
            fit_reg    <= item.fitness;
            draw_a_reg <= item.rand_a;
            draw_b_reg <= item.rand_b;
        end
        else if (ctl.mod_step)
        begin
            draw_a_reg <= {draw_a_reg[DRAW_W-2:0], 1'b0};
            draw_b_reg <= {draw_b_reg[DRAW_W-2:0], 1'b0};
        end

        if (ctl.mod_start)
        begin
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else if (ctl.mod_step)
        begin
            rem_a_reg <= rem_step(rem_a_reg, draw_a_reg[DRAW_W-1], divisor);
            rem_b_reg <= rem_step(rem_b_reg, draw_b_reg[DRAW_W-1], divisor);
        end

        if (ctl.mag_load)
        begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
        end

        if (ctl.shift_init)
        begin
            vic_reg <= vic_is_b ? rd_b_reg : rd_a_reg;
        end
    end

    // Output register: hold the result until the transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            case (ctl.out_sel)
                OSEL_VICTIM:
                begin
                    out_status_reg <= ST_OK;
                    out_id_reg     <= vic_reg[ENT_W-1:FIT_W];
                    out_fit_reg    <= vic_reg[FIT_W-1:0];
                    out_live_reg   <= LIVE_W'(count_reg);
                    out_last_reg   <= 1'b1;
                end
                OSEL_DRAIN:
                begin
                    out_status_reg <= ST_OK;
                    out_id_reg     <= rd_a_reg[ENT_W-1:FIT_W];
                    out_fit_reg    <= rd_a_reg[FIT_W-1:0];
                    out_live_reg   <= '0;
                    out_last_reg   <= drain_last;
                end
                default:
                begin
                    out_status_reg <= ctl.out_status;
                    out_id_reg     <= '0;
                    out_fit_reg    <= '0;
                    out_live_reg   <= LIVE_W'(count_reg);
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.survivor_id      = out_id_reg;
    assign result.survivor_fitness = out_fit_reg;
    assign result.live_count       = out_live_reg;
    assign result.last             = out_last_reg;

    always_comb
    begin
        stat            = '0;
        stat.item_cmd   = cmd_reg;
        stat.item_valid = item.valid;
        stat.full       = count_reg == CNT_W'(POP_MAX);
        stat.empty      = count_reg == '0;
        stat.at_target  = TARGET_W'(count_reg) <= target_reg;
        stat.mod_done   = step_reg == STEP_W'(DRAW_W);
        stat.same_pos   = pos_a == pos_b;
        stat.shift_done = !rd_more && !pend_reg;
        stat.drain_last = drain_last;
        stat.out_free   = !out_valid_reg || result.ready;
    end

endmodule

// File: rtl/core/tes_ctrl.sv
// Controller: sequences load, tournament and drain steps over the datapath.
module tes_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  tes_pkg::dp_status_t stat,
    output tes_pkg::ctl_cmd_t   ctl
);
    import tes_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_MOD      = 11'b000_0000_0100,
        S_CHECK    = 11'b000_0000_1000,
        S_MAG      = 11'b000_0001_0000,
        S_CMP      = 11'b000_0010_0000,
        S_SHIFT    = 11'b000_0100_0000,
        S_EMIT     = 11'b000_1000_0000,
        S_DR_RD    = 11'b001_0000_0000,
        S_DR_EMIT  = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    status_t  status_reg;
    status_t  status_next;
    out_sel_t sel_reg;
    out_sel_t sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            sel_reg    <= OSEL_INFO;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            sel_reg    <= sel_next;
        end
    end

    always_comb
    begin
        ctl         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        sel_next    = sel_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                ctl.take = 1'b1;
                if (stat.item_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                sel_next    = OSEL_INFO;
                status_next = ST_OK;
                unique case (stat.item_cmd)
                    CMD_LOAD:
                    begin
                        state_next = S_EMIT;
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.load_write = 1'b1;
                        end
                    end
                    CMD_TOURN:
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_EMIT;
                        end
                        else if (stat.at_target)
                        begin
                            status_next = ST_AT_TARGET;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            ctl.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                    end
                    CMD_DRAIN:
                    begin
                        if (stat.empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            ctl.drain_init = 1'b1;
                            state_next     = S_DR_RD;
                        end
                    end
                    default:
                    begin
                        // Unused command: drop the item.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    ctl.mod_step = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (stat.same_pos)
                begin
                    status_next = ST_RETRY;
                    state_next  = S_EMIT;
                end
                else
                begin
                    ctl.rd_pair = 1'b1;
                    state_next  = S_MAG;
                end
            end
            S_MAG:
            begin
                ctl.mag_load = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                ctl.shift_init = 1'b1;
                state_next     = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    ctl.cnt_dec = 1'b1;
                    sel_next    = OSEL_VICTIM;
                    state_next  = S_EMIT;
                end
                else
                begin
                    ctl.shift_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_sel    = sel_reg;
                    ctl.out_status = status_reg;
                    state_next     = S_IDLE;
                end
            end
            S_DR_RD:
            begin
                ctl.drain_rd = 1'b1;
                state_next   = S_DR_EMIT;
            end
            S_DR_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load  = 1'b1;
                    ctl.out_sel   = OSEL_DRAIN;
                    ctl.drain_adv = 1'b1;
                    if (stat.drain_last)
                    begin
                        ctl.cnt_clr = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DR_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tes_checker.sv
// Checker: port-level properties of the tournament selector, bound to the top level.
`include "tournament_elimination_select_defines.svh"

module tes_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [tes_pkg::STAT_W-1:0]  result_status,
    input logic [tes_pkg::ID_W-1:0]    result_id,
    input logic [tes_pkg::FIT_W-1:0]   result_fitness,
    input logic [tes_pkg::LIVE_W-1:0]  result_live_count,
    input logic                        result_last
);
    import tes_pkg::*;

    logic                               res_not_ok;
    logic                               res_zero;
    logic                               stalled;
    logic [STAT_W+ID_W+FIT_W+LIVE_W:0]  res_word;

    assign res_not_ok = result_valid && (result_status != ST_OK);
    assign res_zero   = (result_id == '0) && (result_fitness == '0);
    assign stalled    = result_valid && !result_ready;
    assign res_word   = {result_status, result_id, result_fitness, result_live_count,
                         result_last};

    // One item in flight: drop ready right after a transfer.
    `TES_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "item taken while busy")

    // Ready again only once every result but a final one has gone out.
    `TES_ASSERT_NOW(a_idle_last, item_ready && result_valid, result_last, "ready mid item")

    `TES_ASSERT_NOW(a_zero_fields, res_not_ok, res_zero, "non-ok result carries an entry")

    `TES_ASSERT_NEXT(a_hold, stalled, result_valid && $stable(res_word), "stalled result changed")

endmodule

bind tournament_elimination_select tes_checker u_tes_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_status     (result.status),
    .result_id         (result.survivor_id),
    .result_fitness    (result.survivor_fitness),
    .result_live_count (result.live_count),
    .result_last       (result.last)
);
